/* rtl/alu8_pkg.sv */
// shared types and constants for the 8-bit alu execute block
`timescale 1ns / 1ps

package alu8_pkg;

    localparam int BYTE_W     = 8;
    localparam int MODE_W     = 5;
    localparam int IDX_RAW_W  = 5;
    localparam int WORD_W     = 16;
    localparam int WORD_IMM_W = 6;

    // fixed destination pair of the multiplies
    localparam int R0_IDX = 0;
    localparam int R1_IDX = 1;

    localparam logic [BYTE_W-1:0] BYTE_MIN_NEG = 8'h80;
    localparam logic [BYTE_W-1:0] BYTE_MAX_POS = 8'h7F;

    typedef enum logic [MODE_W-1:0] {
        OP_ADD    = 5'd0,
        OP_ADC    = 5'd1,
        OP_ADIW   = 5'd2,
        OP_SUB    = 5'd3,
        OP_SBC    = 5'd4,
        OP_SUBI   = 5'd5,
        OP_SBCI   = 5'd6,
        OP_SBIW   = 5'd7,
        OP_NEG    = 5'd8,
        OP_INC    = 5'd9,
        OP_DEC    = 5'd10,
        OP_ASR    = 5'd11,
        OP_MUL    = 5'd12,
        OP_MULS   = 5'd13,
        OP_MULSU  = 5'd14,
        OP_FMUL   = 5'd15,
        OP_FMULS  = 5'd16,
        OP_FMULSU = 5'd17,
        OP_TST    = 5'd18,
        OP_CP     = 5'd19,
        OP_CPC    = 5'd20,
        OP_CPI    = 5'd21
    } t_op;

    typedef struct packed {
        logic h;
        logic s;
        logic v;
        logic n;
        logic z;
        logic c;
    } t_flags;

    // which bytes an item writes back
    typedef struct packed {
        logic lo_en;
        logic hi_en;
        logic to_r01;
    } t_wr_ctl;

endpackage

/* rtl/alu8_if.sv */
// item and result channel interfaces
`timescale 1ns / 1ps

interface alu8_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [alu8_pkg::MODE_W-1:0]       mode;
    logic [alu8_pkg::IDX_RAW_W-1:0]    dest_index;
    logic [alu8_pkg::IDX_RAW_W-1:0]    source_index;
    logic [alu8_pkg::BYTE_W-1:0]       immediate;

    modport source (output valid, output mode, output dest_index, output source_index,
                    output immediate, input ready);
    modport sink   (input valid, input mode, input dest_index, input source_index,
                    input immediate, output ready);
endinterface

interface alu8_res_if;
    logic                          valid;
    logic                          ready;
    logic [alu8_pkg::BYTE_W-1:0]   result_low;
    logic [alu8_pkg::BYTE_W-1:0]   result_high;
    logic                          carry_flag;
    logic                          zero_flag;
    logic                          negative_flag;
    logic                          overflow_flag;
    logic                          sign_flag;
    logic                          half_carry_flag;

    modport source (output valid, output result_low, output result_high, output carry_flag,
                    output zero_flag, output negative_flag, output overflow_flag,
                    output sign_flag, output half_carry_flag, input ready);
    modport sink   (input valid, input result_low, input result_high, input carry_flag,
                    input zero_flag, input negative_flag, input overflow_flag,
                    input sign_flag, input half_carry_flag, output ready);
endinterface

/* rtl/alu8_ram.sv */
// generic ram, one write port, two registered read ports
`timescale 1ns / 1ps

module alu8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns the old contents on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

/* rtl/alu8_rf.sv */
// register file: two ram banks split by register parity, valid bits and write forwarding
`timescale 1ns / 1ps

module alu8_rf #(
    parameter int REG_COUNT = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_rd_en,
    input  logic [alu8_pkg::IDX_RAW_W-1:0]     i_dest_raw,
    input  logic [alu8_pkg::IDX_RAW_W-1:0]     i_src_raw,
    input  logic                               i_wr_en,
    input  alu8_pkg::t_wr_ctl                  i_wr_ctl,
    input  logic [alu8_pkg::BYTE_W-1:0]        i_wr_lo,
    input  logic [alu8_pkg::BYTE_W-1:0]        i_wr_hi,
    output logic [alu8_pkg::BYTE_W-1:0]        o_op_d,
    output logic [alu8_pkg::BYTE_W-1:0]        o_op_dh,
    output logic [alu8_pkg::BYTE_W-1:0]        o_op_r
);

    localparam int  IDX_W   = $clog2(REG_COUNT);
    localparam int  ROWS    = REG_COUNT / 2;
    localparam int  ROW_W   = $clog2(ROWS);
    localparam int  EXT_W   = alu8_pkg::IDX_RAW_W + 1;
    // with an odd count the last register lives in a flop of its own
    localparam bit  HAS_TOP = (REG_COUNT % 2) == 1;
    localparam int  TOP_IDX = REG_COUNT - 1;

    typedef logic [IDX_W-1:0]            t_idx;
    typedef logic [alu8_pkg::BYTE_W-1:0] t_byte;

    function automatic logic f_is_top(input t_idx x);
        return HAS_TOP && (x == IDX_W'(TOP_IDX));
    endfunction

    function automatic logic [ROW_W-1:0] f_row(input t_idx x);
        return x[ROW_W:1];
    endfunction

    logic [EXT_W-1:0] w_dest_ext;
    logic [EXT_W-1:0] w_src_ext;
    logic [EXT_W-1:0] w_next_ext;
    t_idx             w_di;
    t_idx             w_dh;
    t_idx             w_si;

    t_idx             r_di;
    t_idx             r_dh;
    t_idx             r_si;

    logic [ROW_W-1:0] w_ra_a [2];
    logic [ROW_W-1:0] w_ra_b [2];
    t_byte            w_rd_a [2];
    t_byte            w_rd_b [2];

    logic             w_bank_we    [2];
    logic [ROW_W-1:0] w_bank_waddr [2];
    t_byte            w_bank_wdata [2];

    t_idx             w_wi [2];
    logic             w_we [2];
    t_byte            w_wd [2];

    logic [REG_COUNT-1:0] r_valid;
    logic [1:0]           r_lw_en;
    t_idx                 r_lw_idx  [2];
    t_byte                r_lw_data [2];
    t_byte                r_top;

    t_idx                 w_op_idx [3];
    t_byte                w_mem    [3];
    t_byte                w_op     [3];

    // register numbers wrap at the register count
    always_comb begin
        w_dest_ext = {1'b0, i_dest_raw};
        if (w_dest_ext >= EXT_W'(REG_COUNT)) begin
            w_dest_ext = w_dest_ext - EXT_W'(REG_COUNT);
        end
        w_src_ext = {1'b0, i_src_raw};
        if (w_src_ext >= EXT_W'(REG_COUNT)) begin
            w_src_ext = w_src_ext - EXT_W'(REG_COUNT);
        end
    end

    assign w_di       = w_dest_ext[IDX_W-1:0];
    assign w_si       = w_src_ext[IDX_W-1:0];
    assign w_next_ext = EXT_W'(w_di) + EXT_W'(1);
    assign w_dh       = (w_next_ext == EXT_W'(REG_COUNT)) ? '0 : w_next_ext[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_di <= w_di;
            r_dh <= w_dh;
            r_si <= w_si;
        end
    end

    // write lanes: lane 0 carries the low byte, lane 1 the high byte
    assign w_wi[0] = i_wr_ctl.to_r01 ? IDX_W'(alu8_pkg::R0_IDX) : r_di;
    assign w_wi[1] = i_wr_ctl.to_r01 ? IDX_W'(alu8_pkg::R1_IDX) : r_dh;
    assign w_we[0] = i_wr_en && i_wr_ctl.lo_en;
    assign w_we[1] = i_wr_en && i_wr_ctl.hi_en;
    assign w_wd[0] = i_wr_lo;
    assign w_wd[1] = i_wr_hi;

    for (genvar k = 0; k < 2; k++) begin : g_bank
        // d and its pair partner never share a bank
        assign w_ra_a[k] = ((w_di[0] == 1'(k)) && !f_is_top(w_di)) ? f_row(w_di) : f_row(w_dh);
        assign w_ra_b[k] = f_row(w_si);

        always_comb begin
            w_bank_we[k]    = 1'b0;
            w_bank_waddr[k] = f_row(w_wi[0]);
            w_bank_wdata[k] = w_wd[0];
            if (w_we[0] && !f_is_top(w_wi[0]) && (w_wi[0][0] == 1'(k))) begin
                w_bank_we[k] = 1'b1;
            end else if (w_we[1] && !f_is_top(w_wi[1]) && (w_wi[1][0] == 1'(k))) begin
                w_bank_we[k]    = 1'b1;
                w_bank_waddr[k] = f_row(w_wi[1]);
                w_bank_wdata[k] = w_wd[1];
            end
        end

        alu8_ram #(
            .WIDTH (alu8_pkg::BYTE_W),
            .DEPTH (ROWS)
        ) u_bank (
            .i_clk     (i_clk),
            .i_we      (w_bank_we[k]),
            .i_waddr   (w_bank_waddr[k]),
            .i_wdata   (w_bank_wdata[k]),
            .i_re      (i_rd_en),
            .i_raddr_a (w_ra_a[k]),
            .i_raddr_b (w_ra_b[k]),
            .o_rdata_a (w_rd_a[k]),
            .o_rdata_b (w_rd_b[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_lw_en <= '0;
            r_top   <= '0;
        end else begin
            for (int l = 0; l < 2; l++) begin
                if (w_we[l]) begin
                    r_valid[w_wi[l]] <= 1'b1;
                end
            end
            if (w_we[0] && f_is_top(w_wi[0])) begin
                r_top <= w_wd[0];
            end else if (w_we[1] && f_is_top(w_wi[1])) begin
                r_top <= w_wd[1];
            end
            if (i_wr_en) begin
                r_lw_en <= {w_we[1], w_we[0]};
            end
        end
    end

    // last write is kept to cover the read that overlapped it
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            for (int l = 0; l < 2; l++) begin
                r_lw_idx[l]  <= w_wi[l];
                r_lw_data[l] <= w_wd[l];
            end
        end
    end

    assign w_op_idx[0] = r_di;
    assign w_op_idx[1] = r_dh;
    assign w_op_idx[2] = r_si;
    assign w_mem[0]    = w_rd_a[r_di[0]];
    assign w_mem[1]    = w_rd_a[r_dh[0]];
    assign w_mem[2]    = w_rd_b[r_si[0]];

    always_comb begin
        for (int o = 0; o < 3; o++) begin
            w_op[o] = r_valid[w_op_idx[o]] ? w_mem[o] : '0;
            for (int l = 0; l < 2; l++) begin
                if (r_lw_en[l] && (r_lw_idx[l] == w_op_idx[o])) begin
                    w_op[o] = r_lw_data[l];
                end
            end
            if (f_is_top(w_op_idx[o])) begin
                w_op[o] = r_top;
            end
        end
    end

    assign o_op_d  = w_op[0];
    assign o_op_dh = w_op[1];
    assign o_op_r  = w_op[2];

    a_lanes_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we[0] && w_we[1]) |-> (w_wi[0] != w_wi[1]))
        else $error("both write lanes hit one register");

endmodule

/* rtl/alu8_core.sv */
// combinational execute: operand bytes and flags in, result bytes, flags and write enables out
`timescale 1ns / 1ps

module alu8_core (
    input  logic [alu8_pkg::MODE_W-1:0]  i_mode,
    input  logic [alu8_pkg::BYTE_W-1:0]  i_op_d,
    input  logic [alu8_pkg::BYTE_W-1:0]  i_op_dh,
    input  logic [alu8_pkg::BYTE_W-1:0]  i_op_r,
    input  logic [alu8_pkg::BYTE_W-1:0]  i_imm,
    input  alu8_pkg::t_flags             i_flags,
    output logic [alu8_pkg::BYTE_W-1:0]  o_res_lo,
    output logic [alu8_pkg::BYTE_W-1:0]  o_res_hi,
    output alu8_pkg::t_flags             o_flags,
    output alu8_pkg::t_wr_ctl            o_wr_ctl
);

    localparam int BW = alu8_pkg::BYTE_W;
    localparam int WW = alu8_pkg::WORD_W;

    alu8_pkg::t_op          w_op;
    logic                   w_use_imm;
    logic                   w_use_cin;
    logic                   w_keep_z;
    logic                   w_cin;
    logic [BW-1:0]          w_b;
    logic [BW-1:0]          w_add;
    logic [BW-1:0]          w_sub;
    logic [WW-1:0]          w_word;
    logic [WW-1:0]          w_word_k;
    logic [WW-1:0]          w_word_sum;
    logic [WW-1:0]          w_word_dif;
    logic [BW-1:0]          w_neg;
    logic [BW-1:0]          w_inc;
    logic [BW-1:0]          w_dec;
    logic [BW-1:0]          w_asr;
    logic                   w_a_sgn;
    logic                   w_b_sgn;
    logic                   w_frac;
    logic signed [BW:0]     w_ma;
    logic signed [BW:0]     w_mb;
    logic signed [2*BW+1:0] w_prod;
    logic [WW-1:0]          w_p;
    logic [WW-1:0]          w_pf;

    assign w_op = alu8_pkg::t_op'(i_mode);

    assign w_use_imm = (w_op == alu8_pkg::OP_SUBI) || (w_op == alu8_pkg::OP_SBCI) ||
                       (w_op == alu8_pkg::OP_CPI);
    assign w_keep_z  = (w_op == alu8_pkg::OP_SBC) || (w_op == alu8_pkg::OP_SBCI) ||
                       (w_op == alu8_pkg::OP_CPC);
    assign w_use_cin = w_keep_z || (w_op == alu8_pkg::OP_ADC);
    assign w_cin     = w_use_cin && i_flags.c;
    assign w_b       = w_use_imm ? i_imm : i_op_r;

    assign w_add = i_op_d + w_b + BW'(w_cin);
    assign w_sub = i_op_d - w_b - BW'(w_cin);

    assign w_word     = {i_op_dh, i_op_d};
    assign w_word_k   = WW'(i_imm[alu8_pkg::WORD_IMM_W-1:0]);
    assign w_word_sum = w_word + w_word_k;
    assign w_word_dif = w_word - w_word_k;

    assign w_neg = BW'(0) - i_op_d;
    assign w_inc = i_op_d + BW'(1);
    assign w_dec = i_op_d - BW'(1);
    assign w_asr = {i_op_d[BW-1], i_op_d[BW-1:1]};

    // one 9x9 signed multiplier covers the signed, unsigned and mixed forms
    assign w_a_sgn = !((w_op == alu8_pkg::OP_MUL) || (w_op == alu8_pkg::OP_FMUL));
    assign w_b_sgn = (w_op == alu8_pkg::OP_MULS) || (w_op == alu8_pkg::OP_FMULS);
    assign w_frac  = (w_op == alu8_pkg::OP_FMUL) || (w_op == alu8_pkg::OP_FMULS) ||
                     (w_op == alu8_pkg::OP_FMULSU);
    assign w_ma    = {w_a_sgn & i_op_d[BW-1], i_op_d};
    assign w_mb    = {w_b_sgn & i_op_r[BW-1], i_op_r};
    assign w_prod  = w_ma * w_mb;
    assign w_p     = w_prod[WW-1:0];
    assign w_pf    = w_frac ? {w_p[WW-2:0], 1'b0} : w_p;

    always_comb begin
        o_flags  = i_flags;
        o_res_lo = '0;
        o_res_hi = '0;
        o_wr_ctl = '0;
        unique case (w_op) inside
            alu8_pkg::OP_ADD, alu8_pkg::OP_ADC: begin
                o_res_lo  = w_add;
                o_flags.h = (i_op_d[3] & w_b[3]) | (w_b[3] & ~w_add[3]) |
                            (~w_add[3] & i_op_d[3]);
                o_flags.c = (i_op_d[7] & w_b[7]) | (w_b[7] & ~w_add[7]) |
                            (~w_add[7] & i_op_d[7]);
                o_flags.v = (i_op_d[7] & w_b[7] & ~w_add[7]) |
                            (~i_op_d[7] & ~w_b[7] & w_add[7]);
                o_flags.z = (w_add == '0);
                o_flags.n = w_add[7];
                o_flags.s = o_flags.n ^ o_flags.v;
                o_wr_ctl.lo_en = 1'b1;
            end
            alu8_pkg::OP_SUB, alu8_pkg::OP_SBC, alu8_pkg::OP_SUBI, alu8_pkg::OP_SBCI,
            alu8_pkg::OP_CP, alu8_pkg::OP_CPC, alu8_pkg::OP_CPI: begin
                o_res_lo  = w_sub;
                o_flags.h = (~i_op_d[3] & w_b[3]) | (w_b[3] & w_sub[3]) |
                            (w_sub[3] & ~i_op_d[3]);
                o_flags.c = (~i_op_d[7] & w_b[7]) | (w_b[7] & w_sub[7]) |
                            (w_sub[7] & ~i_op_d[7]);
                o_flags.v = (i_op_d[7] & ~w_b[7] & ~w_sub[7]) |
                            (~i_op_d[7] & w_b[7] & w_sub[7]);
                // with borrow in, zero only sticks if it was already set
                o_flags.z = (w_sub == '0) && (!w_keep_z || i_flags.z);
                o_flags.n = w_sub[7];
                o_flags.s = o_flags.n ^ o_flags.v;
                o_wr_ctl.lo_en = (w_op != alu8_pkg::OP_CP) && (w_op != alu8_pkg::OP_CPC) &&
                                 (w_op != alu8_pkg::OP_CPI);
            end
            alu8_pkg::OP_ADIW: begin
                o_res_lo  = w_word_sum[BW-1:0];
                o_res_hi  = w_word_sum[WW-1:BW];
                o_flags.v = ~i_op_dh[7] & w_word_sum[WW-1];
                o_flags.c = ~w_word_sum[WW-1] & i_op_dh[7];
                o_flags.z = (w_word_sum == '0);
                o_flags.n = w_word_sum[WW-1];
                o_flags.s = o_flags.n ^ o_flags.v;
                o_wr_ctl.lo_en = 1'b1;
                o_wr_ctl.hi_en = 1'b1;
            end
            alu8_pkg::OP_SBIW: begin
                o_res_lo  = w_word_dif[BW-1:0];
                o_res_hi  = w_word_dif[WW-1:BW];
                o_flags.v = i_op_dh[7] & ~w_word_dif[WW-1];
                o_flags.c = w_word_dif[WW-1] & ~i_op_dh[7];
                o_flags.z = (w_word_dif == '0);
                o_flags.n = w_word_dif[WW-1];
                o_flags.s = o_flags.n ^ o_flags.v;
                o_wr_ctl.lo_en = 1'b1;
                o_wr_ctl.hi_en = 1'b1;
            end
            alu8_pkg::OP_NEG: begin
                o_res_lo  = w_neg;
                o_flags.h = (i_op_d[3:0] != '0);
                o_flags.c = (w_neg != '0);
                o_flags.v = (w_neg == alu8_pkg::BYTE_MIN_NEG);
                o_flags.z = (w_neg == '0);
                o_flags.n = w_neg[7];
                o_flags.s = o_flags.n ^ o_flags.v;
                o_wr_ctl.lo_en = 1'b1;
            end
            alu8_pkg::OP_INC: begin
                o_res_lo  = w_inc;
                o_flags.v = (w_inc == alu8_pkg::BYTE_MIN_NEG);
                o_flags.z = (w_inc == '0);
                o_flags.n = w_inc[7];
                o_flags.s = o_flags.n ^ o_flags.v;
                o_wr_ctl.lo_en = 1'b1;
            end
            alu8_pkg::OP_DEC: begin
                o_res_lo  = w_dec;
                o_flags.v = (w_dec == alu8_pkg::BYTE_MAX_POS);
                o_flags.z = (w_dec == '0);
                o_flags.n = w_dec[7];
                o_flags.s = o_flags.n ^ o_flags.v;
                o_wr_ctl.lo_en = 1'b1;
            end
            alu8_pkg::OP_ASR: begin
                o_res_lo  = w_asr;
                o_flags.c = i_op_d[0];
                o_flags.v = w_asr[7] ^ i_op_d[0];
                o_flags.z = (w_asr == '0);
                o_flags.n = w_asr[7];
                o_flags.s = o_flags.n ^ o_flags.v;
                o_wr_ctl.lo_en = 1'b1;
            end
            alu8_pkg::OP_MUL, alu8_pkg::OP_MULS, alu8_pkg::OP_MULSU,
            alu8_pkg::OP_FMUL, alu8_pkg::OP_FMULS, alu8_pkg::OP_FMULSU: begin
                // carry is taken before the fractional shift
                o_res_lo  = w_pf[BW-1:0];
                o_res_hi  = w_pf[WW-1:BW];
                o_flags.c = w_p[WW-1];
                o_flags.z = (w_pf == '0);
                o_wr_ctl.lo_en  = 1'b1;
                o_wr_ctl.hi_en  = 1'b1;
                o_wr_ctl.to_r01 = 1'b1;
            end
            alu8_pkg::OP_TST: begin
                o_res_lo  = i_op_d;
                o_flags.v = 1'b0;
                o_flags.z = (i_op_d == '0);
                o_flags.n = i_op_d[7];
                o_flags.s = i_op_d[7];
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/eight_bit_alu_execute.sv */
// top level of the 8-bit alu execute block
`timescale 1ns / 1ps

// Executes one 8-bit arithmetic or multiply instruction per item against a
// REGISTER_COUNT-byte register file and the C Z N V S H flags, and returns the
// written byte(s) and the full new flag set. One item is accepted every clock
// cycle when the result side does not stall, dependent items included. The edge
// that accepts an item also captures the register file bank reads (registered ram
// reads). The alu or the 9x9 multiplier then works on them, and at the edge where
// the item leaves that stage the output register loads and the register file and
// flags are written. The register file reads as all zero after reset without any
// clearing pass; stalls on the result side hold the pipeline and back-pressure the
// item side.
module eight_bit_alu_execute #(
    parameter int REGISTER_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    alu8_cmd_if.sink    i_cmd,
    alu8_res_if.source  o_res
);

    logic                              r_s1_vld;
    logic [alu8_pkg::MODE_W-1:0]       r_mode;
    logic [alu8_pkg::BYTE_W-1:0]       r_imm;
    alu8_pkg::t_flags                  r_flags;

    logic                              r_out_vld;
    logic [alu8_pkg::BYTE_W-1:0]       r_res_lo;
    logic [alu8_pkg::BYTE_W-1:0]       r_res_hi;
    alu8_pkg::t_flags                  r_res_flags;

    logic                              w_out_load;
    logic                              w_s1_adv;
    logic                              w_cmd_ready;
    logic                              w_accept;

    logic [alu8_pkg::BYTE_W-1:0]       w_op_d;
    logic [alu8_pkg::BYTE_W-1:0]       w_op_dh;
    logic [alu8_pkg::BYTE_W-1:0]       w_op_r;
    logic [alu8_pkg::BYTE_W-1:0]       w_lo;
    logic [alu8_pkg::BYTE_W-1:0]       w_hi;
    alu8_pkg::t_flags                  w_flags;
    alu8_pkg::t_wr_ctl                 w_wr_ctl;

    assign w_out_load  = !r_out_vld || o_res.ready;
    assign w_s1_adv    = r_s1_vld && w_out_load;
    assign w_cmd_ready = !r_s1_vld || w_s1_adv;
    assign w_accept    = i_cmd.valid && w_cmd_ready;

    assign i_cmd.ready = w_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_flags   <= '0;
        end else begin
            if (w_cmd_ready) begin
                r_s1_vld <= i_cmd.valid;
            end
            if (w_out_load) begin
                r_out_vld <= r_s1_vld;
            end
            if (w_s1_adv) begin
                r_flags <= w_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_cmd.mode;
            r_imm  <= i_cmd.immediate;
        end
        if (w_s1_adv) begin
            r_res_lo    <= w_lo;
            r_res_hi    <= w_hi;
            r_res_flags <= w_flags;
        end
    end

    alu8_rf #(
        .REG_COUNT (REGISTER_COUNT)
    ) u_rf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_accept),
        .i_dest_raw (i_cmd.dest_index),
        .i_src_raw  (i_cmd.source_index),
        .i_wr_en    (w_s1_adv),
        .i_wr_ctl   (w_wr_ctl),
        .i_wr_lo    (w_lo),
        .i_wr_hi    (w_hi),
        .o_op_d     (w_op_d),
        .o_op_dh    (w_op_dh),
        .o_op_r     (w_op_r)
    );

    alu8_core u_core (
        .i_mode   (r_mode),
        .i_op_d   (w_op_d),
        .i_op_dh  (w_op_dh),
        .i_op_r   (w_op_r),
        .i_imm    (r_imm),
        .i_flags  (r_flags),
        .o_res_lo (w_lo),
        .o_res_hi (w_hi),
        .o_flags  (w_flags),
        .o_wr_ctl (w_wr_ctl)
    );

    assign o_res.valid           = r_out_vld;
    assign o_res.result_low      = r_res_lo;
    assign o_res.result_high     = r_res_hi;
    assign o_res.carry_flag      = r_res_flags.c;
    assign o_res.zero_flag       = r_res_flags.z;
    assign o_res.negative_flag   = r_res_flags.n;
    assign o_res.overflow_flag   = r_res_flags.v;
    assign o_res.sign_flag       = r_res_flags.s;
    assign o_res.half_carry_flag = r_res_flags.h;

    a_flags_match_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> (r_out_vld && (r_res_flags == r_flags)))
        else $error("reported flags differ from the flag register");

    a_flags_only_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s1_adv |=> $stable(r_flags))
        else $error("flags changed without a committed item");

    a_stalled_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_s1_adv) |=> (r_s1_vld && $stable(r_mode)))
        else $error("stalled item lost or changed");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> w_cmd_ready)
        else $error("input stalled with an empty output register");

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the 8-bit alu execute block
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_GAP      = 6;
    localparam int RANDOM_ITEMS = 480;
    localparam int HOLD_AFTER   = 120;
    localparam int HOLD_CYCLES  = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REG_COUNT    = 32;
    localparam int MODE_NOP_LO  = int'(alu8_pkg::OP_CPI) + 1;
    localparam int MODE_MAX     = (1 << alu8_pkg::MODE_W) - 1;

    typedef logic [alu8_pkg::BYTE_W-1:0]    t_byte;
    typedef logic [alu8_pkg::MODE_W-1:0]    t_mode;
    typedef logic [alu8_pkg::IDX_RAW_W-1:0] t_ridx;
    typedef logic [alu8_pkg::WORD_W-1:0]    t_word;

    typedef struct packed {
        t_mode mode;
        t_ridx dest;
        t_ridx src;
        t_byte imm;
    } t_alu_in;

    typedef struct packed {
        t_byte            lo;
        t_byte            hi;
        alu8_pkg::t_flags fl;
    } t_alu_out;

    logic i_clk = 1'b0;
    logic i_rst_n;

    alu8_cmd_if cmd_ch();
    alu8_res_if res_ch();

    eight_bit_alu_execute u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // predicted machine state
    t_byte             gpr_shadow [REG_COUNT];
    alu8_pkg::t_flags  sreg_shadow;

    t_alu_in  pending_items    [$];
    t_alu_out expected_results [$];

    t_byte imm_corners [7] = '{8'h00, 8'h01, 8'h3F, 8'h40, 8'h7F, 8'h80, 8'hFF};

    int   n_total;
    int   n_accepted = 0;
    int   n_checked  = 0;
    int   n_errors   = 0;
    int   n_undefined = 0;
    bit   mode_seen [MODE_MAX+1];
    int   cmd_gap = 0;
    int   rx_gap  = 0;
    bit   cmd_calm = 1'b0;
    bit   rx_calm  = 1'b0;
    logic rx_hold  = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n             = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.mode         = '0;
        cmd_ch.dest_index   = '0;
        cmd_ch.source_index = '0;
        cmd_ch.immediate    = '0;
        res_ch.ready        = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_error(string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic compare_field(string field, t_byte got, t_byte want);
        if (got !== want)
            report_error($sformatf("result %0d: %s is %h, expected %h",
                                   n_checked, field, got, want));
    endtask

    function automatic void set_sign(logic n);
        sreg_shadow.n = n;
        sreg_shadow.s = n ^ sreg_shadow.v;
    endfunction

    function automatic t_byte add_bytes(t_byte d, t_byte r, logic cin);
        t_byte s;
        s = d + r + cin;
        sreg_shadow.h = (d[3] & r[3]) | (r[3] & ~s[3]) | (~s[3] & d[3]);
        sreg_shadow.c = (d[7] & r[7]) | (r[7] & ~s[7]) | (~s[7] & d[7]);
        sreg_shadow.v = (d[7] & r[7] & ~s[7]) | (~d[7] & ~r[7] & s[7]);
        sreg_shadow.z = (s == '0);
        set_sign(s[7]);
        return s;
    endfunction

    // with keep_z the zero flag can only stay set, as for multi-byte chains
    function automatic t_byte sub_bytes(t_byte d, t_byte r, logic cin, logic keep_z);
        t_byte s;
        s = d - r - cin;
        sreg_shadow.h = (~d[3] & r[3]) | (r[3] & s[3]) | (s[3] & ~d[3]);
        sreg_shadow.c = (~d[7] & r[7]) | (r[7] & s[7]) | (s[7] & ~d[7]);
        sreg_shadow.v = (d[7] & ~r[7] & ~s[7]) | (~d[7] & r[7] & s[7]);
        sreg_shadow.z = keep_z ? ((s == '0) && sreg_shadow.z) : (s == '0);
        set_sign(s[7]);
        return s;
    endfunction

    function automatic t_alu_out execute_insn(t_alu_in it);
        t_ridx    di, si, dh_i;
        t_byte    d, r, k;
        logic     cin, h7, signed_a, signed_b, frac;
        t_word    w, p;
        int       a, b, prod;
        t_alu_out o;
        di   = it.dest;
        si   = it.src;
        dh_i = di + 1'b1;  // pair wraps at the top of the file
        d    = gpr_shadow[di];
        r    = gpr_shadow[si];
        k    = it.imm;
        cin  = sreg_shadow.c;
        o.lo = '0;
        o.hi = '0;
        case (it.mode)
            alu8_pkg::OP_ADD: begin
                o.lo = add_bytes(d, r, 1'b0);
                gpr_shadow[di] = o.lo;
            end
            alu8_pkg::OP_ADC: begin
                o.lo = add_bytes(d, r, cin);
                gpr_shadow[di] = o.lo;
            end
            alu8_pkg::OP_ADIW, alu8_pkg::OP_SBIW: begin
                h7 = gpr_shadow[dh_i][7];
                w  = {gpr_shadow[dh_i], d};
                if (it.mode == alu8_pkg::OP_ADIW) begin
                    w = w + k[alu8_pkg::WORD_IMM_W-1:0];
                    sreg_shadow.v = ~h7 & w[15];
                    sreg_shadow.c = h7 & ~w[15];
                end else begin
                    w = w - k[alu8_pkg::WORD_IMM_W-1:0];
                    sreg_shadow.v = h7 & ~w[15];
                    sreg_shadow.c = ~h7 & w[15];
                end
                sreg_shadow.z = (w == '0);
                set_sign(w[15]);
                o.lo = w[7:0];
                o.hi = w[15:8];
                gpr_shadow[di]   = o.lo;
                gpr_shadow[dh_i] = o.hi;
            end
            alu8_pkg::OP_SUB: begin
                o.lo = sub_bytes(d, r, 1'b0, 1'b0);
                gpr_shadow[di] = o.lo;
            end
            alu8_pkg::OP_SBC: begin
                o.lo = sub_bytes(d, r, cin, 1'b1);
                gpr_shadow[di] = o.lo;
            end
            alu8_pkg::OP_SUBI: begin
                o.lo = sub_bytes(d, k, 1'b0, 1'b0);
                gpr_shadow[di] = o.lo;
            end
            alu8_pkg::OP_SBCI: begin
                o.lo = sub_bytes(d, k, cin, 1'b1);
                gpr_shadow[di] = o.lo;
            end
            alu8_pkg::OP_NEG: begin
                o.lo = 8'h00 - d;
                sreg_shadow.h = (d[3:0] != '0);
                sreg_shadow.c = (o.lo != '0);
                sreg_shadow.v = (o.lo == alu8_pkg::BYTE_MIN_NEG);
                sreg_shadow.z = (o.lo == '0);
                set_sign(o.lo[7]);
                gpr_shadow[di] = o.lo;
            end
            alu8_pkg::OP_INC, alu8_pkg::OP_DEC: begin
                if (it.mode == alu8_pkg::OP_INC) begin
                    o.lo = d + 1'b1;
                    sreg_shadow.v = (o.lo == alu8_pkg::BYTE_MIN_NEG);
                end else begin
                    o.lo = d - 1'b1;
                    sreg_shadow.v = (o.lo == alu8_pkg::BYTE_MAX_POS);
                end
                sreg_shadow.z = (o.lo == '0);
                set_sign(o.lo[7]);
                gpr_shadow[di] = o.lo;
            end
            alu8_pkg::OP_ASR: begin
                o.lo = {d[7], d[7:1]};
                sreg_shadow.c = d[0];
                sreg_shadow.v = o.lo[7] ^ d[0];
                sreg_shadow.z = (o.lo == '0);
                set_sign(o.lo[7]);
                gpr_shadow[di] = o.lo;
            end
            alu8_pkg::OP_MUL, alu8_pkg::OP_MULS, alu8_pkg::OP_MULSU,
            alu8_pkg::OP_FMUL, alu8_pkg::OP_FMULS, alu8_pkg::OP_FMULSU: begin
                signed_a = !(it.mode == alu8_pkg::OP_MUL || it.mode == alu8_pkg::OP_FMUL);
                signed_b = (it.mode == alu8_pkg::OP_MULS || it.mode == alu8_pkg::OP_FMULS);
                frac     = (it.mode == alu8_pkg::OP_FMUL || it.mode == alu8_pkg::OP_FMULS ||
                            it.mode == alu8_pkg::OP_FMULSU);
                a = int'(d);
                b = int'(r);
                if (signed_a && d[7]) a = a - 256;
                if (signed_b && r[7]) b = b - 256;
                prod = a * b;
                p    = prod[15:0];
                // carry comes from the product before the fractional shift
                sreg_shadow.c = p[15];
                if (frac) p = p << 1;
                sreg_shadow.z = (p == '0);
                o.lo = p[7:0];
                o.hi = p[15:8];
                gpr_shadow[alu8_pkg::R0_IDX] = o.lo;
                gpr_shadow[alu8_pkg::R1_IDX] = o.hi;
            end
            alu8_pkg::OP_TST: begin
                o.lo = d;
                sreg_shadow.v = 1'b0;
                sreg_shadow.z = (d == '0);
                set_sign(d[7]);
            end
            alu8_pkg::OP_CP:  o.lo = sub_bytes(d, r, 1'b0, 1'b0);
            alu8_pkg::OP_CPC: o.lo = sub_bytes(d, r, cin, 1'b1);
            alu8_pkg::OP_CPI: o.lo = sub_bytes(d, k, 1'b0, 1'b0);
            default: ;
        endcase
        o.fl = sreg_shadow;
        return o;
    endfunction

    task automatic queue_item(t_mode mode, t_ridx dest, t_ridx src, t_byte imm);
        t_alu_in it;
        it.mode = mode;
        it.dest = dest;
        it.src  = src;
        it.imm  = imm;
        pending_items.push_back(it);
    endtask

    // low registers often, to hit the multiply targets and build dependency chains
    function automatic t_ridx pick_reg();
        if ($urandom_range(0, 99) < 40)
            return t_ridx'($urandom_range(0, 3));
        return t_ridx'($urandom_range(0, REG_COUNT - 1));
    endfunction

    function automatic t_alu_in random_item();
        t_alu_in it;
        if ($urandom_range(0, 99) < 5)
            it.mode = t_mode'($urandom_range(MODE_NOP_LO, MODE_MAX));
        else
            it.mode = t_mode'($urandom_range(int'(alu8_pkg::OP_ADD), int'(alu8_pkg::OP_CPI)));
        it.dest = pick_reg();
        it.src  = pick_reg();
        if ($urandom_range(0, 99) < 20)
            it.imm = imm_corners[$urandom_range(0, 6)];
        else
            it.imm = t_byte'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // item driver
    always @(posedge i_clk) begin : cmd_driver
        t_alu_in it;
        int      g;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            cmd_gap      <= 0;
        end else begin
            g = cmd_gap;
            if (cmd_ch.valid && cmd_ch.ready) begin
                it.mode = cmd_ch.mode;
                it.dest = cmd_ch.dest_index;
                it.src  = cmd_ch.source_index;
                it.imm  = cmd_ch.immediate;
                expected_results.push_back(execute_insn(it));
                mode_seen[it.mode] = 1'b1;
                if (it.mode >= MODE_NOP_LO) n_undefined++;
                n_accepted++;
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (g > 0) begin
                    cmd_ch.valid <= 1'b0;
                    g = g - 1;
                end else if (pending_items.size() != 0) begin
                    it = pending_items.pop_front();
                    cmd_ch.mode         <= it.mode;
                    cmd_ch.dest_index   <= it.dest;
                    cmd_ch.source_index <= it.src;
                    cmd_ch.immediate    <= it.imm;
                    cmd_ch.valid        <= 1'b1;
                    if ($urandom_range(0, 23) == 0) cmd_calm = ~cmd_calm;
                    g = draw_gap(cmd_calm);
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
            cmd_gap <= g;
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin : res_monitor
        t_alu_out want;
        int       g;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            rx_gap       <= 0;
        end else begin
            g = rx_gap;
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_error($sformatf("result %0d arrived with no item outstanding",
                                           n_checked));
                end else begin
                    want = expected_results.pop_front();
                    compare_field("result_low", res_ch.result_low, want.lo);
                    compare_field("result_high", res_ch.result_high, want.hi);
                    compare_field("carry_flag", t_byte'(res_ch.carry_flag),
                                  t_byte'(want.fl.c));
                    compare_field("zero_flag", t_byte'(res_ch.zero_flag),
                                  t_byte'(want.fl.z));
                    compare_field("negative_flag", t_byte'(res_ch.negative_flag),
                                  t_byte'(want.fl.n));
                    compare_field("overflow_flag", t_byte'(res_ch.overflow_flag),
                                  t_byte'(want.fl.v));
                    compare_field("sign_flag", t_byte'(res_ch.sign_flag),
                                  t_byte'(want.fl.s));
                    compare_field("half_carry_flag", t_byte'(res_ch.half_carry_flag),
                                  t_byte'(want.fl.h));
                end
                n_checked++;
                if ($urandom_range(0, 23) == 0) rx_calm = ~rx_calm;
                g = draw_gap(rx_calm);
            end else if (g > 0) begin
                g = g - 1;
            end
            rx_gap       <= g;
            res_ch.ready <= (g == 0) && !rx_hold;
        end
    end

    // one long receiver stall so the pipeline backs up into the item side
    initial begin : rx_hold_ctl
        while (n_accepted < HOLD_AFTER) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin : no_progress_watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: nothing moved for %0d cycles, %0d of %0d items in, %0d results out",
                 STALL_LIMIT, n_accepted, n_total, n_checked);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int n_modes;
        for (int i = 0; i < REG_COUNT; i++) gpr_shadow[i] = '0;
        sreg_shadow = '0;

        // directed: loads through subtract-immediate from zero, then every operation
        queue_item(alu8_pkg::OP_ADD,    5'd0,  5'd0,  8'h00);
        queue_item(alu8_pkg::OP_SUBI,   5'd16, 5'd0,  8'h01);
        queue_item(alu8_pkg::OP_SUBI,   5'd17, 5'd0,  8'h80);
        queue_item(alu8_pkg::OP_SUBI,   5'd31, 5'd0,  8'h81);
        queue_item(alu8_pkg::OP_ADC,    5'd16, 5'd16, 8'h00);
        queue_item(alu8_pkg::OP_SBC,    5'd2,  5'd16, 8'h00);
        queue_item(alu8_pkg::OP_SBCI,   5'd3,  5'd0,  8'hFF);
        queue_item(alu8_pkg::OP_ADIW,   5'd31, 5'd0,  8'hFF);  // pair wraps to r0
        queue_item(alu8_pkg::OP_SBIW,   5'd24, 5'd0,  8'h3F);
        queue_item(alu8_pkg::OP_NEG,    5'd17, 5'd0,  8'h00);
        queue_item(alu8_pkg::OP_MUL,    5'd16, 5'd16, 8'h00);
        queue_item(alu8_pkg::OP_MULS,   5'd17, 5'd17, 8'h00);
        queue_item(alu8_pkg::OP_MULSU,  5'd17, 5'd16, 8'h00);
        queue_item(alu8_pkg::OP_FMUL,   5'd16, 5'd16, 8'h00);
        queue_item(alu8_pkg::OP_FMULS,  5'd17, 5'd17, 8'h00);
        queue_item(alu8_pkg::OP_FMULSU, 5'd17, 5'd16, 8'h00);
        queue_item(alu8_pkg::OP_DEC,    5'd17, 5'd0,  8'h00);
        queue_item(alu8_pkg::OP_INC,    5'd17, 5'd0,  8'h00);
        queue_item(alu8_pkg::OP_ASR,    5'd17, 5'd0,  8'h00);
        queue_item(alu8_pkg::OP_SUB,    5'd17, 5'd31, 8'h00);
        queue_item(alu8_pkg::OP_TST,    5'd5,  5'd0,  8'h00);
        queue_item(alu8_pkg::OP_CP,     5'd16, 5'd16, 8'h00);
        queue_item(alu8_pkg::OP_CPC,    5'd16, 5'd16, 8'h00);
        queue_item(alu8_pkg::OP_CPI,    5'd16, 5'd0,  8'hFF);
        queue_item(t_mode'(MODE_NOP_LO), 5'd7, 5'd8,  8'h5A);
        queue_item(t_mode'(MODE_MAX),   5'd31, 5'd31, 8'hFF);

        repeat (RANDOM_ITEMS) pending_items.push_back(random_item());
        n_total = pending_items.size();

        while (!i_rst_n) @(posedge i_clk);
        while (n_accepted < n_total || expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        n_modes = 0;
        for (int m = 0; m < MODE_NOP_LO; m++) if (mode_seen[m]) n_modes++;
        $display("run covered %0d of %0d instructions plus %0d undefined-mode items",
                 n_modes, MODE_NOP_LO, n_undefined);
        $display("%0d items in, %0d results checked, %0d mismatches, one %0d-cycle output stall",
                 n_accepted, n_checked, n_errors, HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* eight_bit_alu_execute.f */
rtl/alu8_pkg.sv
rtl/alu8_if.sv
rtl/alu8_ram.sv
rtl/alu8_rf.sv
rtl/alu8_core.sv
rtl/eight_bit_alu_execute.sv
tb/tb_top.sv
